// File: design/jda_pkg.sv
// Shared types, constants and helpers for the job dispatch autoscaler.
// No dependencies; every other design file imports this package.
package jda_pkg;

  // default sizing, handed to the top-level parameters
  localparam int MAX_SERVERS_DEF   = 64;
  localparam int FIFO_DEPTH_DEF    = 256;
  localparam int DURATION_BITS_DEF = 8;

  // configuration registers
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_INIT_W   = 7;
  localparam int CFG_CAP_W    = 8;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SERVERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAP    = 1'd1;
  localparam logic [CFG_INIT_W-1:0] INIT_SERVERS_RST = 7'd10;
  localparam logic [CFG_CAP_W-1:0]  QUEUE_CAP_RST    = 8'd50;

  // queue must sit within this many slots of capacity before a server is added
  localparam int SCALE_UP_MARGIN = 2;

  // operation codes on the input word
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // command kinds after front-end decode
  localparam logic [1:0] KIND_ENQ     = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] job_duration;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [8:0]  queue_count;
    logic [6:0]  active_servers;
    logic [6:0]  assigned_now;
    logic [6:0]  finished_now;
    logic [31:0] rejected_total;
    logic [31:0] finished_total;
  } out_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] duration;
  } cmd_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// File: design/jda_front.sv
// Front end: takes input words, decodes the operation and holds commands
// in a two-entry queue for the back end. Depends on jda_pkg.
module jda_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  jda_pkg::in_word_t in_word,
  output logic             cmd_valid,
  input  logic             cmd_pop,
  output jda_pkg::cmd_t    cmd
);
  import jda_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       dec;

  always_comb begin
    dec.duration = in_word.job_duration;
    case (in_word.operation)
      OP_ENQUEUE: dec.kind = KIND_ENQ;
      OP_TICK:    dec.kind = KIND_TICK;
      OP_RESTART: dec.kind = KIND_RESTART;
      default:    dec.kind = KIND_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: design/jda_back.sv
// Back end: job FIFO, server table and the tick walker; drives the result
// register. Depends on jda_pkg.
module jda_back #(
  parameter int MAX_SERVERS   = jda_pkg::MAX_SERVERS_DEF,
  parameter int FIFO_DEPTH    = jda_pkg::FIFO_DEPTH_DEF,
  parameter int DURATION_BITS = jda_pkg::DURATION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_pop,
  input  jda_pkg::cmd_t                     cmd,
  input  logic [jda_pkg::CFG_INIT_W-1:0]    init_servers,
  input  logic [jda_pkg::CFG_CAP_W-1:0]     queue_cap,
  output logic                              out_valid,
  input  logic                              out_stall,
  output jda_pkg::out_word_t                out_word
);
  import jda_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
  localparam int SIDX_W = $clog2(MAX_SERVERS);
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int DUR_W  = DURATION_BITS;
  localparam int CAPW   = ((FILL_W > CFG_CAP_W) ? FILL_W : CFG_CAP_W) + 1;
  localparam int CMPW   = (CNT_W > CFG_INIT_W) ? CNT_W : CFG_INIT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;

  // memories: job durations, and {holding, countdown} per server
  logic [DUR_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [DUR_W:0]   srv_mem  [MAX_SERVERS];
  logic [DUR_W-1:0] fifo_rd_r;
  logic [DUR_W:0]   srv_rd_r;

  logic [1:0]             state_r, state_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       asg_r, asg_nxt;
  logic [CNT_W-1:0]       fin_r, fin_nxt;
  logic [31:0]            rej_tot_r, rej_tot_nxt;
  logic [31:0]            fin_tot_r, fin_tot_nxt;
  logic [MAX_SERVERS-1:0] vld_r, vld_nxt;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  logic              out_free;
  logic              out_load;
  logic              acc_now;
  logic              fifo_we;
  logic [PTR_W-1:0]  fifo_waddr;
  logic [DUR_W-1:0]  dur;
  logic              srv_we;
  logic [DUR_W:0]    srv_wdata;
  logic [SIDX_W-1:0] sidx;
  logic [SIDX_W-1:0] last_idx;
  logic [SUM_W-1:0]  tail_sum;
  logic [CAPW-1:0]   fill_ext;
  logic [CAPW-1:0]   cap_ext;
  logic [CMPW-1:0]   cnt_cmp;
  logic [CMPW-1:0]   init_cmp;
  logic [CMPW-1:0]   max_cmp;
  logic              scale_up;
  logic              scale_dn;
  logic [DUR_W-1:0]  cd_cur;
  logic              hold_cur;
  logic [DUR_W-1:0]  cd_dec;
  logic [PTR_W-1:0]  head_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign sidx     = idx_r[SIDX_W-1:0];
  assign last_idx = SIDX_W'(count_r - CNT_W'(1));
  assign dur      = DUR_W'(cmd.duration);
  assign fill_ext = CAPW'(fill_r);
  assign cap_ext  = CAPW'(queue_cap);
  assign cnt_cmp  = CMPW'(count_r);
  assign init_cmp = CMPW'(init_servers);
  assign max_cmp  = CMPW'(MAX_SERVERS);
  assign scale_up = (fill_ext + CAPW'(SCALE_UP_MARGIN)) > cap_ext;
  assign scale_dn = (fill_ext <= (cap_ext >> 1)) && (cnt_cmp > init_cmp);
  assign head_inc = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign cd_cur   = vld_r[sidx] ? srv_rd_r[DUR_W-1:0] : '0;
  assign hold_cur = vld_r[sidx] ? srv_rd_r[DUR_W] : 1'b0;
  assign cd_dec   = (cd_cur != '0) ? cd_cur - DUR_W'(1) : cd_cur;

  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(fill_r);
    if (tail_sum >= SUM_W'(FIFO_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(FIFO_DEPTH);
    end
    fifo_waddr = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    asg_nxt     = asg_r;
    fin_nxt     = fin_r;
    rej_tot_nxt = rej_tot_r;
    fin_tot_nxt = fin_tot_r;
    vld_nxt     = vld_r;
    cmd_pop     = 1'b0;
    out_load    = 1'b0;
    acc_now     = 1'b0;
    fifo_we     = 1'b0;
    srv_we      = 1'b0;
    srv_wdata   = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          asg_nxt = '0;
          fin_nxt = '0;
          case (cmd.kind)
            KIND_ENQ: begin
              out_load = 1'b1;
              if (fill_ext > cap_ext || fill_r >= FILL_W'(FIFO_DEPTH)) begin
                rej_tot_nxt = sat_inc32(rej_tot_r);
              end else begin
                fifo_we  = 1'b1;
                fill_nxt = fill_r + FILL_W'(1);
                acc_now  = 1'b1;
              end
            end
            KIND_TICK: begin
              if (scale_up) begin
                if (cnt_cmp < max_cmp) begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end else if (scale_dn) begin
                // the dropped server's job is lost without counting
                count_nxt         = count_r - CNT_W'(1);
                vld_nxt[last_idx] = 1'b0;
              end
              idx_nxt = '0;
              if (count_nxt == '0) begin
                out_load = 1'b1;
              end else begin
                state_nxt = S_RD;
              end
            end
            KIND_RESTART: begin
              out_load    = 1'b1;
              head_nxt    = '0;
              fill_nxt    = '0;
              rej_tot_nxt = '0;
              fin_tot_nxt = '0;
              vld_nxt     = '0;
              count_nxt   = (init_cmp > max_cmp) ? CNT_W'(MAX_SERVERS)
                                                 : CNT_W'(init_servers);
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        // memory reads of server idx and FIFO head land this edge
        state_nxt = S_EX;
      end
      S_EX: begin
        srv_we        = 1'b1;
        vld_nxt[sidx] = 1'b1;
        if (cd_cur == '0 && fill_r != '0) begin
          srv_wdata = {1'b1, fifo_rd_r};
          head_nxt  = head_inc;
          fill_nxt  = fill_r - FILL_W'(1);
          asg_nxt   = asg_r + CNT_W'(1);
        end else if (cd_dec == '0 && hold_cur) begin
          srv_wdata   = {1'b0, cd_dec};
          fin_tot_nxt = sat_inc32(fin_tot_r);
          fin_nxt     = fin_r + CNT_W'(1);
        end else begin
          srv_wdata = {hold_cur, cd_dec};
        end
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_nxt == count_r) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      count_r     <= (CMPW'(INIT_SERVERS_RST) > CMPW'(MAX_SERVERS)) ?
                     CNT_W'(MAX_SERVERS) : CNT_W'(INIT_SERVERS_RST);
      idx_r       <= '0;
      asg_r       <= '0;
      fin_r       <= '0;
      rej_tot_r   <= '0;
      fin_tot_r   <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      asg_r     <= asg_nxt;
      fin_r     <= fin_nxt;
      rej_tot_r <= rej_tot_nxt;
      fin_tot_r <= fin_tot_nxt;
      vld_r     <= vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.accepted       <= acc_now;
      out_word_r.queue_count    <= 9'(fill_nxt);
      out_word_r.active_servers <= 7'(count_nxt);
      out_word_r.assigned_now   <= 7'(asg_nxt);
      out_word_r.finished_now   <= 7'(fin_nxt);
      out_word_r.rejected_total <= rej_tot_nxt;
      out_word_r.finished_total <= fin_tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= dur;
    end
    fifo_rd_r <= fifo_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (srv_we) begin
      srv_mem[sidx] <= srv_wdata;
    end
    srv_rd_r <= srv_mem[sidx];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: design/job_dispatch_autoscaler_unit.sv
// Job dispatch autoscaler, top level: configuration registers, front end
// and back end. Depends on jda_pkg, jda_front and jda_back.
// Enqueue, restart and unknown codes: front-end queue, then result register; one result
// per cycle while the output is not stalled and no tick walk runs. Tick: scaling, then
// a table read (S_RD) and update (S_EX) per active server, or the result if none is active.
// A two-word command queue keeps taking input while the back end works.
// Synchronous active-low reset: servers idle, totals zero, 10 servers, capacity 50.
module job_dispatch_autoscaler_unit #(
  parameter int MAX_SERVERS   = jda_pkg::MAX_SERVERS_DEF,
  parameter int FIFO_DEPTH    = jda_pkg::FIFO_DEPTH_DEF,
  parameter int DURATION_BITS = jda_pkg::DURATION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  jda_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output jda_pkg::out_word_t              out_word,
  input  logic                            cfg_we,
  input  logic [jda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jda_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jda_pkg::*;

  logic [CFG_INIT_W-1:0] init_r;
  logic [CFG_CAP_W-1:0]  cap_r;
  logic                  cmd_valid;
  logic                  cmd_pop;
  cmd_t                  cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= INIT_SERVERS_RST;
      cap_r  <= QUEUE_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_SERVERS: init_r <= cfg_data[CFG_INIT_W-1:0];
        REG_QUEUE_CAP:    cap_r  <= cfg_data[CFG_CAP_W-1:0];
        default: ;
      endcase
    end
  end

  jda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  jda_back #(
    .MAX_SERVERS   (MAX_SERVERS),
    .FIFO_DEPTH    (FIFO_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .init_servers (init_r),
    .queue_cap    (cap_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word)
  );

  // only an enqueue can accept, and an enqueue never dispatches or finishes
  a_accept_only_enq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.accepted) |->
      (out_word.assigned_now == 7'd0 && out_word.finished_now == 7'd0))
    else $error("accepted word carries tick activity");

  // each walked server either takes a job or finishes one, never both
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (MAX_SERVERS < 128)) |->
      ((8'(out_word.assigned_now) + 8'(out_word.finished_now))
        <= 8'(out_word.active_servers)))
    else $error("tick activity exceeds active servers");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.accepted && (FIFO_DEPTH < 512)) |->
      (out_word.queue_count != 9'd0))
    else $error("accepted job left queue empty");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for job_dispatch_autoscaler_unit: directed and random enqueue/tick/restart words,
// each result word checked field by field against an in-bench model of queue and server pool.
// Depends on jda_pkg and the design sources; reads no files.
module tb;
  import jda_pkg::*;

  localparam int NSRV          = MAX_SERVERS_DEF;
  localparam int QDEPTH        = FIFO_DEPTH_DEF;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * NSRV + 8;
  localparam logic [1:0] OP_UNDEF = 2'd3;  // unused code, block must leave state alone

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  job_dispatch_autoscaler_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // pool model state
  logic [7:0]  job_q [QDEPTH];
  int unsigned job_head, job_fill;
  logic [7:0]  srv_left [NSRV];
  bit          srv_holds [NSRV];
  int unsigned pool_size, rej_total, fin_total;
  int unsigned init_servers, queue_cap;

  out_word_t   expected_q [$];
  out_word_t   want;

  int unsigned tx_idle_pct = 0, rx_stall_pct = 0, rx_hold_left = 0;
  int unsigned cycles = 0, mismatches = 0, n_items = 0, n_results = 0, n_configs = 0;
  int unsigned seen_rejects = 0, seen_finished = 0, seen_full = 0, peak_pool = 0;

  function automatic in_word_t mk_word(logic [1:0] op, logic [7:0] dur);
    in_word_t w;
    w.operation    = op;
    w.job_duration = dur;
    return w;
  endfunction

  function automatic void pool_restart();
    for (int i = 0; i < NSRV; i++) begin
      srv_left[i]  = '0;
      srv_holds[i] = 1'b0;
    end
    job_head  = 0;
    job_fill  = 0;
    rej_total = 0;
    fin_total = 0;
    pool_size = (init_servers > NSRV) ? NSRV : init_servers;
  endfunction

  function automatic void pool_tick(output int unsigned assigned, output int unsigned finished);
    assigned = 0;
    finished = 0;
    if (job_fill + 2 > queue_cap) begin
      if (pool_size < NSRV) pool_size++;
    end else if (job_fill <= queue_cap / 2 && pool_size > init_servers) begin
      // last server leaves, its job is lost uncounted
      pool_size--;
      srv_left[pool_size]  = '0;
      srv_holds[pool_size] = 1'b0;
    end
    for (int i = 0; i < pool_size; i++) begin
      if (srv_left[i] == 0 && job_fill > 0) begin
        srv_left[i]  = job_q[job_head];
        srv_holds[i] = 1'b1;
        job_head     = (job_head + 1) % QDEPTH;
        job_fill--;
        assigned++;
      end else begin
        if (srv_left[i] != 0) srv_left[i]--;
        if (srv_left[i] == 0 && srv_holds[i]) begin
          srv_holds[i] = 1'b0;
          if (fin_total != 32'hFFFF_FFFF) fin_total++;
          finished++;
        end
      end
    end
    if (pool_size > peak_pool) peak_pool = pool_size;
  endfunction

  function automatic out_word_t dispatch_predict(in_word_t w);
    out_word_t   r;
    int unsigned assigned, finished;
    r        = '0;
    assigned = 0;
    finished = 0;
    case (w.operation)
      OP_ENQUEUE: begin
        if (job_fill > queue_cap || job_fill >= QDEPTH) begin
          if (job_fill >= QDEPTH) seen_full++;
          if (rej_total != 32'hFFFF_FFFF) rej_total++;
          seen_rejects++;
        end else begin
          job_q[(job_head + job_fill) % QDEPTH] = w.job_duration;
          job_fill++;
          r.accepted = 1'b1;
        end
      end
      OP_TICK: pool_tick(assigned, finished);
      OP_RESTART: pool_restart();
      default: ;
    endcase
    seen_finished    += finished;
    r.queue_count    = 9'(job_fill);
    r.active_servers = 7'(pool_size);
    r.assigned_now   = 7'(assigned);
    r.finished_now   = 7'(finished);
    r.rejected_total = rej_total;
    r.finished_total = fin_total;
    return r;
  endfunction

  function automatic in_word_t random_word(int unsigned enq_pct);
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2)                          w.operation = OP_RESTART;
    else if (pick < 4)                     w.operation = OP_UNDEF;
    else if ($urandom_range(99) < enq_pct) w.operation = OP_ENQUEUE;
    else                                   w.operation = OP_TICK;
    // mostly short jobs so servers free up and finish within a phase
    pick = $urandom_range(9);
    if (pick < 6)      w.job_duration = 8'($urandom_range(7));
    else if (pick < 9) w.job_duration = 8'($urandom_range(40));
    else               w.job_duration = 8'($urandom);
    return w;
  endfunction

  task automatic check_field(input string label, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual %h",
                 $time, out_word);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_word.accepted));
        check_field("queue_count", 32'(want.queue_count), 32'(out_word.queue_count));
        check_field("active_servers", 32'(want.active_servers),
                    32'(out_word.active_servers));
        check_field("assigned_now", 32'(want.assigned_now), 32'(out_word.assigned_now));
        check_field("finished_now", 32'(want.finished_now), 32'(out_word.finished_now));
        check_field("rejected_total", want.rejected_total, out_word.rejected_total);
        check_field("finished_total", want.finished_total, out_word.finished_total);
        n_results++;
      end
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  task automatic send_word(input in_word_t w);
    out_word_t pred;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred       = dispatch_predict(w);
    expected_q = {expected_q, pred};
    n_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_pool(input int unsigned init, input int unsigned cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_INIT_SERVERS;
    cfg_data  <= CFG_DATA_W'(init);
    @(posedge clk);
    cfg_index <= REG_QUEUE_CAP;
    cfg_data  <= CFG_DATA_W'(cap);
    @(posedge clk);
    cfg_we       <= 1'b0;
    init_servers = init & 32'h7F;
    queue_cap    = cap & 32'hFF;
    n_configs++;
  endtask

  task automatic test_directed();
    send_word(mk_word(OP_ENQUEUE, 8'h00));
    send_word(mk_word(OP_TICK, 8'hFF));
    send_word(mk_word(OP_TICK, 8'h00));     // zero-length job finishes on empty queue
    send_word(mk_word(OP_ENQUEUE, 8'h00));
    send_word(mk_word(OP_TICK, 8'h00));
    send_word(mk_word(OP_ENQUEUE, 8'h03));
    send_word(mk_word(OP_TICK, 8'h00));     // server 0 drops its zero-length job
    send_word(mk_word(OP_ENQUEUE, 8'hFF));
    send_word(mk_word(OP_ENQUEUE, 8'h55));
    send_word(mk_word(OP_ENQUEUE, 8'hAA));
    send_word(mk_word(OP_ENQUEUE, 8'h01));
    repeat (4) send_word(mk_word(OP_TICK, 8'h00));
    send_word(mk_word(OP_UNDEF, 8'hFF));
    send_word(mk_word(OP_RESTART, 8'hFF));
    send_word(mk_word(OP_ENQUEUE, 8'h02));
    repeat (4) send_word(mk_word(OP_TICK, 8'h00));
  endtask

  // no servers and the widest capacity: queue storage itself runs out
  task automatic test_full_storage();
    program_pool(0, 255);
    send_word(mk_word(OP_RESTART, 8'h00));
    repeat (QDEPTH + 3) send_word(mk_word(OP_ENQUEUE, 8'($urandom)));
    repeat (4) send_word(mk_word(OP_TICK, 8'($urandom)));
  endtask

  task automatic test_backpressure();
    program_pool(4, 20);
    send_word(mk_word(OP_RESTART, 8'h00));
    rx_hold_left = 300;
    repeat (24) send_word(random_word(70));
    wait_idle();
    repeat (16) send_word(random_word(50));
  endtask

  task automatic run_random_phase(input int unsigned init, input int unsigned cap,
                                  input int unsigned count);
    int unsigned enq_pct, burst;
    program_pool(init, cap);
    send_word(mk_word(OP_RESTART, 8'h00));
    enq_pct = 50;
    burst   = 0;
    for (int n = 0; n < count; n++) begin
      // bursts of filling and draining push the queue across the scaling thresholds
      if (burst == 0) begin
        burst = $urandom_range(8, 40);
        case ($urandom_range(2))
          0:       enq_pct = 90;
          1:       enq_pct = 60;
          default: enq_pct = 25;
        endcase
      end
      burst--;
      send_word(random_word(enq_pct));
    end
  endtask

  initial begin
    init_servers = 32'(INIT_SERVERS_RST);
    queue_cap    = 32'(QUEUE_CAP_RST);
    pool_restart();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(37, 72);
    test_directed();
    test_full_storage();
    run_random_phase(10, 50, 100);
    run_random_phase(1, 4, 90);

    set_idling(72, 37);
    test_backpressure();
    run_random_phase(0, 2, 90);
    run_random_phase(64, 254, 90);
    run_random_phase(127, 0, 60);

    set_idling(0, 0);
    run_random_phase(3, 15, 90);
    run_random_phase(2, 1, 70);
    run_random_phase($urandom_range(127), $urandom_range(255), 90);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d words in, %0d results checked, %0d register settings, %0d cycles",
             n_items, n_results, n_configs, cycles);
    $display("tb: %0d rejects (%0d on full storage), %0d jobs finished, pool peaked at %0d",
             seen_rejects, seen_full, seen_finished, peak_pool);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
